// ----- hw/rtl/swab_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swab_pkg
// Shared types and codes for the sliding window average buffer.
// ----------------------------------------------------------------------------
package swab_pkg;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_IGNORE = 2'd3;  // no result; only the command fields are latched

  // register indexes; byte address is 4 * index
  localparam int REG_WINDOW_LENGTH = 0;
  localparam int REG_AVG_ORDER     = 1;

  localparam int MAX_OUT = 64;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture the command fields
    logic wr_sample;  // write the appended sample
    logic clr_start;  // begin a zeroing pass
    logic clr_step;   // zero one slot
    logic scan_start; // begin the average / zero scan
    logic scan_step;  // accumulate one slot
    logic div_start;  // begin the division
    logic div_step;   // one quotient bit
    logic emit_start; // reset the read pointer
    logic emit_step;  // fetch one sample for output
    logic wp_clear;   // drop the write position
  } swab_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic div_done;
    logic emit_last;
  } swab_stat_t;

endpackage

// ----- hw/rtl/swab_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swab_ctrl
// Sequencer: clear, append, scan, divide and emit phases.
// ----------------------------------------------------------------------------
module swab_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           command,
  input  logic [6:0]           count,
  input  logic                 cfg_len_wr,
  input  swab_pkg::swab_stat_t stat,
  output swab_pkg::swab_cmd_t  cmd,
  output logic                 busy,
  output logic                 emit_valid
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLR   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_FETCH = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    emit_valid = 1'b0;
    case (state)
      S_IDLE: begin
        if (cfg_len_wr) begin
          cmd.clr_start = 1'b1;
          cmd.wp_clear  = 1'b1;
          state_next    = S_CLR;
        end else if (start) begin
          cmd.latch = 1'b1;
          case (command)
            swab_pkg::CMD_APPEND: begin
              cmd.wr_sample  = 1'b1;
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            swab_pkg::CMD_READ: begin
              if (count != 7'd0) begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
              end
            end
            swab_pkg::CMD_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_next    = S_CLR;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.emit_start = 1'b1;
          state_next     = S_FETCH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FETCH: begin
        cmd.emit_step = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        emit_valid = 1'b1;
        if (stat.emit_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.emit_step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The reset clearing pass also uses S_CLR and still raises emit_valid; it is
  // marked by a flag set at reset in the datapath, which the core uses to drop it.
  assign busy = (state != S_IDLE);

endmodule

// ----- hw/rtl/swab_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swab_dp
// Sample memory, write position, accumulator, divider and output registers.
// ----------------------------------------------------------------------------
module swab_dp #(
  parameter int DEPTH      = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  swab_pkg::swab_cmd_t  cmd,
  input  logic [1:0]           command,
  input  logic signed [31:0]   sample,
  input  logic [6:0]           count,
  input  logic [6:0]           window_length,
  input  logic [6:0]           avg_order,
  output swab_pkg::swab_stat_t stat,
  output logic signed [31:0]   data,
  output logic signed [39:0]   average,
  output logic                 all_zero,
  output logic                 suppress
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam int SW = ITEM_WIDTH + CW;   // sum width
  localparam int NW = SW + 8;            // scaled magnitude width

  logic [ITEM_WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]         wp;
  logic [CW-1:0]         len;
  logic [CW-1:0]         k;
  logic [CW-1:0]         idx;
  logic [AW-1:0]         ptr;
  logic [6:0]            n_left;
  logic [1:0]            cmd_q;
  logic signed [SW-1:0]  sum;
  logic                  nz;
  logic [ITEM_WIDTH-1:0] rd;
  logic                  rd_pend;
  logic [NW-1:0]         num;
  logic [CW:0]           rem;
  logic [NW-1:0]         quo;
  logic                  neg;
  logic [6:0]            dbit;
  logic                  boot;

  // effective length and order
  always_comb begin
    if (window_length == 7'd0) begin
      len = CW'(1);
    end else if (int'(window_length) > DEPTH) begin
      len = CW'(DEPTH);
    end else begin
      len = CW'(window_length);
    end
    if (avg_order == 7'd0) begin
      k = CW'(1);
    end else if (int'(avg_order) > int'(len)) begin
      k = len;
    end else begin
      k = CW'(avg_order);
    end
  end

  function automatic logic [AW-1:0] back1(input logic [AW-1:0] p, input logic [CW-1:0] l);
    logic [CW-1:0] t;
    t = (p == '0) ? l - CW'(1) : CW'(p) - CW'(1);
    return t[AW-1:0];
  endfunction

  logic signed [ITEM_WIDTH-1:0] rd_s;
  assign rd_s = rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      boot   <= 1'b1;
      idx    <= '0;
      cmd_q  <= swab_pkg::CMD_CLEAR;
      n_left <= '0;
    end else begin
      if (cmd.latch) begin
        cmd_q  <= command;
        n_left <= (count > 7'(swab_pkg::MAX_OUT)) ? 7'(swab_pkg::MAX_OUT) : count;
        boot   <= 1'b0;
      end
      if (cmd.wp_clear) begin
        wp   <= '0;
        boot <= 1'b1;
      end
      if (cmd.wr_sample) begin
        mem[wp] <= sample[ITEM_WIDTH-1:0];
        wp      <= (CW'(wp) + CW'(1) >= len) ? '0 : wp + AW'(1);
      end
      if (cmd.clr_start) idx <= '0;
      if (cmd.clr_step) begin
        mem[idx[AW-1:0]] <= '0;
        if (!cmd.scan_start) idx <= idx + CW'(1);
      end
      // scan: walk all len slots from the newest backwards
      if (cmd.scan_start) begin
        idx     <= '0;
        ptr     <= back1(cmd.wr_sample ? ((CW'(wp) + CW'(1) >= len) ? '0 : wp + AW'(1))
                                       : wp, len);
        sum     <= '0;
        nz      <= 1'b0;
        rd_pend <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (idx < len) begin
          rd  <= mem[ptr];
          ptr <= back1(ptr, len);
          idx <= idx + CW'(1);
        end
        rd_pend <= (idx < len);
        if (rd_pend) begin
          if (rd != '0) nz <= 1'b1;
          if (idx <= k) sum <= sum + SW'(rd_s);
        end
      end
      if (cmd.div_start) begin
        neg  <= sum[SW-1];
        num  <= {(sum[SW-1] ? -sum : sum), 8'd0};
        rem  <= '0;
        dbit <= 7'(NW);
      end
      if (cmd.div_step) begin
        logic [CW:0] r2;
        r2 = {rem[CW-1:0], num[NW-1]};
        num <= {num[NW-2:0], (r2 >= {1'b0, k})};
        rem <= (r2 >= {1'b0, k}) ? r2 - {1'b0, k} : r2;
        dbit <= dbit - 7'd1;
      end
      if (cmd.emit_start) begin
        quo      <= neg ? -num : num;
        all_zero <= ~nz;
        ptr      <= back1(wp, len);
      end
      if (cmd.emit_step) begin
        if (cmd_q == swab_pkg::CMD_READ) begin
          data <= 32'(signed'(mem[ptr]));
        end else if (cmd_q == swab_pkg::CMD_APPEND) begin
          data <= 32'(signed'(mem[back1(wp, len)]));
        end else begin
          data <= '0;
        end
        ptr <= back1(ptr, len);
        if (n_left != 7'd0) n_left <= n_left - 7'd1;
      end
    end
  end

  assign average        = 40'(signed'(quo));
  assign stat.clr_done  = (idx == CW'(DEPTH - 1));
  assign stat.scan_done = !rd_pend && (idx == len);
  assign stat.div_done  = (dbit == 7'd0);
  assign stat.emit_last = (cmd_q != swab_pkg::CMD_READ) || (n_left == 7'd0);
  assign suppress       = boot;

endmodule

// ----- hw/rtl/sliding_window_average_buffer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_average_buffer_core
// Circular window of signed samples with moving average and zero flag.
// ----------------------------------------------------------------------------
// After an accepted command: a scan of the window, a bit-serial divide and a fetch,
// then results one per cycle; a clear first adds a zeroing pass of DEPTH slots.
// One item at a time: a command is taken only while idle, and busy stays high
// through the scan, the divide and the emission of its results.
// Reset: busy stays high through a DEPTH-slot zeroing pass and a silent scan,
// divide and emit. Results cannot be stalled; each strobe lasts one cycle.
module sliding_window_average_buffer_core #(
  parameter int DEPTH      = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic signed [31:0] sample,
  input  logic [6:0]         count,
  output logic               strobe,
  output logic signed [31:0] data,
  output logic signed [39:0] average,
  output logic               all_zero,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [2:0] ADDR_LEN   = 3'(swab_pkg::REG_WINDOW_LENGTH * 4);
  localparam logic [2:0] ADDR_ORDER = 3'(swab_pkg::REG_AVG_ORDER * 4);

  logic [6:0] window_length;
  logic [6:0] avg_order;
  logic       wr;
  logic       cfg_len_wr;
  logic       emit_valid;
  logic       suppress;
  swab_pkg::swab_cmd_t  cmd;
  swab_pkg::swab_stat_t stat;

  assign pready     = 1'b1;
  assign wr         = psel && penable && pwrite;
  assign cfg_len_wr = wr && (paddr == ADDR_LEN);

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= 7'd64;
      avg_order     <= 7'd1;
    end else if (wr) begin
      if (paddr == ADDR_LEN)   window_length <= pwdata[6:0];
      if (paddr == ADDR_ORDER) avg_order     <= pwdata[6:0];
    end
  end

  assign prdata = (paddr == ADDR_LEN)   ? {25'd0, window_length} :
                  (paddr == ADDR_ORDER) ? {25'd0, avg_order} : 32'd0;

  swab_ctrl u_ctrl (
    .clk, .rst, .start, .command, .count, .cfg_len_wr,
    .stat, .cmd, .busy, .emit_valid
  );

  swab_dp #(.DEPTH(DEPTH), .ITEM_WIDTH(ITEM_WIDTH)) u_dp (
    .clk, .rst, .cmd, .command, .sample, .count, .window_length, .avg_order,
    .stat, .data, .average, .all_zero, .suppress
  );

  // drop results of the internal zeroing passes (reset, length write)
  assign strobe = emit_valid && !suppress;
  assign last   = stat.emit_last;

endmodule
